@@ design/dnh_pkg.sv @@
// ----------------------------------------------------------------------------
// dnh_pkg
// Shared constants, types and tables of the directory name hash block.
// ----------------------------------------------------------------------------
package dnh_pkg;

    localparam int unsigned MAX_NAME_BYTES = 255;

    localparam logic [2:0] CFG_VERSION = 3'd0;
    localparam logic [2:0] CFG_SEED0   = 3'd1;
    localparam logic [2:0] CFG_SEED1   = 3'd2;
    localparam logic [2:0] CFG_SEED2   = 3'd3;
    localparam logic [2:0] CFG_SEED3   = 3'd4;

    localparam logic [2:0] VER_LEGACY   = 3'd0;
    localparam logic [2:0] VER_MD4      = 3'd1;
    localparam logic [2:0] VER_TEA      = 3'd2;
    localparam logic [2:0] VER_LEGACY_U = 3'd3;
    localparam logic [2:0] VER_MD4_U    = 3'd4;
    localparam logic [2:0] VER_TEA_U    = 3'd5;

    localparam logic [31:0] K_MD4_2   = 32'h5A827999;
    localparam logic [31:0] K_MD4_3   = 32'h6ED9EBA1;
    localparam logic [31:0] K_DELTA   = 32'h9E3779B9;
    localparam logic [31:0] K_LEG0    = 32'h12A3FE2D;
    localparam logic [31:0] K_LEG1    = 32'h37ABE8F9;
    localparam logic [31:0] K_LEGMUL  = 32'h006D22F5;
    localparam logic [31:0] K_LEGSUB  = 32'h7FFFFFFF;
    localparam logic [31:0] K_IV0     = 32'h67452301;
    localparam logic [31:0] K_IV1     = 32'hEFCDAB89;
    localparam logic [31:0] K_IV2     = 32'h98BADCFE;
    localparam logic [31:0] K_IV3     = 32'h10325476;

    typedef enum logic [1:0] {
        SCH_LEGACY = 2'd0,
        SCH_MD4    = 2'd1,
        SCH_TEA    = 2'd2,
        SCH_ERROR  = 2'd3
    } t_scheme;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEGACY,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        t_scheme    scheme;
        logic [4:0] round;
    } t_core_ctl;

    function automatic logic [2:0] md4_word(input logic [4:0] k);
        logic [2:0] w;
        case (k)
            5'd8:  w = 3'd1;  5'd9:  w = 3'd3;  5'd10: w = 3'd5;  5'd11: w = 3'd7;
            5'd12: w = 3'd0;  5'd13: w = 3'd2;  5'd14: w = 3'd4;  5'd15: w = 3'd6;
            5'd16: w = 3'd3;  5'd17: w = 3'd7;  5'd18: w = 3'd2;  5'd19: w = 3'd6;
            5'd20: w = 3'd1;  5'd21: w = 3'd5;  5'd22: w = 3'd0;  5'd23: w = 3'd4;
            default: w = k[2:0];
        endcase
        return w;
    endfunction

    function automatic logic [4:0] md4_shift(input logic [4:0] k);
        logic [4:0] s;
        case ({k[4:3], k[1:0]}) inside
            4'b0000, 4'b0100, 4'b1000: s = 5'd3;
            4'b0001: s = 5'd7;
            4'b0010: s = 5'd11;
            4'b0011: s = 5'd19;
            4'b0101: s = 5'd5;
            4'b0110: s = 5'd9;
            4'b0111: s = 5'd13;
            4'b1001: s = 5'd9;
            4'b1010: s = 5'd11;
            4'b1011: s = 5'd15;
            default: s = 5'd3;
        endcase
        return s;
    endfunction

endpackage

@@ design/dnh_if.sv @@
// ----------------------------------------------------------------------------
// dnh_if
// Valid/ready channel interfaces for name bytes and hash results.
// ----------------------------------------------------------------------------
interface dnh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic [7:0] name_length;
    modport source (output valid, name_byte, name_length, input ready);
    modport sink   (input valid, name_byte, name_length, output ready);
endinterface

interface dnh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] major_hash;
    logic [31:0] minor_hash;
    logic        error_flag;
    modport source (output valid, major_hash, minor_hash, error_flag, input ready);
    modport sink   (input valid, major_hash, minor_hash, error_flag, output ready);
endinterface

@@ design/dnh_core.sv @@
// ----------------------------------------------------------------------------
// dnh_core
// Shared round unit: one half-MD4 step or one TEA round per cycle.
// ----------------------------------------------------------------------------
module dnh_core (
    input  logic                     i_clk,
    input  dnh_pkg::t_core_ctl       i_ctl,
    input  logic [31:0]              i_chain [4],
    input  logic [31:0]              i_words [8],
    output logic [31:0]              o_v [4]
);
    import dnh_pkg::*;

    logic [31:0] r_v [4];
    logic [31:0] r_sum;
    logic [31:0] n_v [4];
    logic [31:0] n_sum;
    logic [1:0]  t;
    logic [31:0] x, y, z, f, a, tx, ty;
    logic [4:0]  sh;

    always_comb begin
        n_v   = r_v;
        n_sum = r_sum;
        t  = 2'd0 - i_ctl.round[1:0];
        x  = r_v[t + 2'd1];
        y  = r_v[t + 2'd2];
        z  = r_v[t + 2'd3];
        sh = md4_shift(i_ctl.round);
        if (i_ctl.round < 5'd8) begin
            f = (x & y) | (~x & z);
        end else if (i_ctl.round < 5'd16) begin
            f = ((x & y) | (x & z) | (y & z)) + K_MD4_2;
        end else begin
            f = (x ^ y ^ z) + K_MD4_3;
        end
        a  = r_v[t] + f + i_words[md4_word(i_ctl.round)];
        tx = '0;
        ty = '0;
        if (i_ctl.start) begin
            n_v   = i_chain;
            n_sum = '0;
        end else if (i_ctl.scheme == SCH_MD4) begin
            n_v[t] = (a << sh) | (a >> (6'd32 - {1'b0, sh}));
        end else begin
            n_sum = r_sum + K_DELTA;
            tx = r_v[0] + (((r_v[1] << 4) + i_words[0]) ^ (r_v[1] + n_sum)
                 ^ ((r_v[1] >> 5) + i_words[1]));
            ty = r_v[1] + (((tx << 4) + i_words[2]) ^ (tx + n_sum)
                 ^ ((tx >> 5) + i_words[3]));
            n_v[0] = tx;
            n_v[1] = ty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_sum <= n_sum;
    end

    assign o_v = r_v;
endmodule

@@ design/directory_name_hash.sv @@
// ----------------------------------------------------------------------------
// directory_name_hash
// Directory index hash (legacy, half-MD4, TEA) of a streamed file name.
// ----------------------------------------------------------------------------
// A name is taken one byte per word; the length comes with the first byte.
// A legacy byte is multiplied, then folded. A byte that closes a chunk, or
// the name, loads the shared round unit, runs it through its half-MD4 steps
// or TEA rounds and then updates the chain; other bytes are only stored in
// the chunk words. The result word follows the last byte and sits in an output
// register until taken; no byte is taken while it waits.
module directory_name_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    dnh_in_if.sink      in_ch,
    dnh_out_if.source   out_ch
);
    import dnh_pkg::*;

    logic [2:0]  r_version;
    logic [31:0] r_seed [4];
    t_state      r_state, n_state;
    t_scheme     r_scheme;
    logic        r_uns;
    logic [7:0]  r_pos, r_len;
    logic [31:0] r_chain [4];
    logic [31:0] r_leg [2];
    logic [31:0] r_words [8];
    logic [31:0] r_prod;
    logic [4:0]  r_round;
    logic        r_last;
    logic        r_ovalid;
    logic [31:0] r_major, r_minor;
    logic        r_err;
    t_core_ctl   ctl;
    logic [31:0] core_v [4];
    logic [31:0] init_chain [4];
    logic [31:0] core_chain [4];
    logic [31:0] bx, h0, pad, maj;
    logic [7:0]  p, rem;
    logic        last, closes, first;
    t_scheme     sch;
    logic [4:0]  o;
    logic        acc;
    logic        err_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VER_MD4;
            r_seed[0] <= K_IV0;
            r_seed[1] <= K_IV1;
            r_seed[2] <= K_IV2;
            r_seed[3] <= K_IV3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VERSION: r_version <= i_cfg_wdata[2:0];
                CFG_SEED0:   r_seed[0] <= i_cfg_wdata;
                CFG_SEED1:   r_seed[1] <= i_cfg_wdata;
                CFG_SEED2:   r_seed[2] <= i_cfg_wdata;
                CFG_SEED3:   r_seed[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign acc   = in_ch.valid && in_ch.ready;
    assign first = (r_pos == 8'd0);
    always_comb begin
        if (first) begin
            unique case (r_version) inside
                VER_LEGACY, VER_LEGACY_U: sch = SCH_LEGACY;
                VER_MD4, VER_MD4_U:       sch = SCH_MD4;
                VER_TEA, VER_TEA_U:       sch = SCH_TEA;
                default:                  sch = SCH_ERROR;
            endcase
        end else begin
            sch = r_scheme;
        end
    end
    assign p    = r_pos;
    assign last = ({1'b0, p} + 9'd1) >= {1'b0, (first ? in_ch.name_length : r_len)};
    assign bx   = ((first ? (r_version >= VER_LEGACY_U) : r_uns) || !in_ch.name_byte[7])
                  ? {24'd0, in_ch.name_byte} : {24'hFFFFFF, in_ch.name_byte};
    assign o    = (sch == SCH_MD4) ? p[4:0] : {1'b0, p[3:0]};
    assign closes = last || ((sch == SCH_MD4) ? (p[4:0] == 5'd31) : (p[3:0] == 4'd15));
    assign rem  = (first ? in_ch.name_length : r_len) - p;
    assign pad  = {4{rem}};
    assign h0   = r_leg[1] + (r_leg[0] ^ r_prod);
    assign err_res = acc && ((first && (in_ch.name_length == 8'd0))
                             || (sch == SCH_ERROR && last));

    always_comb begin
        if ((r_seed[0] | r_seed[1] | r_seed[2] | r_seed[3]) == '0) begin
            init_chain[0] = K_IV0;
            init_chain[1] = K_IV1;
            init_chain[2] = K_IV2;
            init_chain[3] = K_IV3;
        end else begin
            init_chain = r_seed;
        end
        if (acc && first) begin
            core_chain = init_chain;
        end else begin
            core_chain = r_chain;
        end
    end

    assign ctl.start  = (r_state == ST_IDLE);
    assign ctl.scheme = r_scheme;
    assign ctl.round  = r_round;

    dnh_core u_core (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_chain (core_chain),
        .i_words (r_words),
        .o_v     (core_v)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && !(first && (in_ch.name_length == 8'd0))
                    && sch != SCH_ERROR) begin
                    if (sch == SCH_LEGACY) n_state = ST_LEGACY;
                    else if (closes) n_state = ST_ROUND;
                end
            end
            ST_LEGACY: n_state = ST_IDLE;
            ST_ROUND: begin
                if ((r_scheme == SCH_MD4 && r_round == 5'd23)
                    || (r_scheme == SCH_TEA && r_round == 5'd15)) n_state = ST_FOLD;
            end
            ST_FOLD: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= 8'd0;
            r_len    <= 8'd0;
            r_ovalid <= 1'b0;
            r_round  <= 5'd0;
            r_scheme <= SCH_LEGACY;
            r_uns    <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (err_res || (r_last && (r_state == ST_LEGACY || r_state == ST_FOLD))) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            r_round <= (r_state == ST_ROUND) ? r_round + 5'd1 : 5'd0;
            if (acc) begin
                r_last <= last;
                if (first) begin
                    r_len    <= in_ch.name_length;
                    r_scheme <= sch;
                    r_uns    <= (r_version >= VER_LEGACY_U);
                end
                if (!(first && in_ch.name_length == 8'd0)) begin
                    r_pos <= last ? 8'd0 : p + 8'd1;
                end
            end
        end
    end

    always_comb begin
        if (r_state == ST_LEGACY) begin
            maj = (h0[31] ? h0 - K_LEGSUB : h0) << 1;
        end else if (r_scheme == SCH_MD4) begin
            maj = r_chain[1] + core_v[1];
        end else begin
            maj = r_chain[0] + core_v[0];
        end
        maj[0] = 1'b0;
        if (maj == 32'hFFFFFFFE) maj = 32'hFFFFFFFC;
    end

    always_ff @(posedge i_clk) begin
        if (acc && first) begin
            r_chain  <= init_chain;
            r_leg[0] <= K_LEG0;
            r_leg[1] <= K_LEG1;
        end
        if (acc) begin
            r_prod <= bx * K_LEGMUL;
            if (o == 5'd0) begin
                r_words[0] <= (pad << 8) + bx;
                for (int w = 1; w < 8; w++) r_words[w] <= pad;
            end else begin
                r_words[o[4:2]] <= (r_words[o[4:2]] << 8) + bx;
            end
            if (err_res) begin
                r_err   <= 1'b1;
                r_major <= '0;
                r_minor <= '0;
            end
        end
        if (r_state == ST_LEGACY) begin
            r_leg[1] <= r_leg[0];
            r_leg[0] <= h0[31] ? h0 - K_LEGSUB : h0;
            if (r_last) begin
                r_major <= maj;
                r_minor <= '0;
                r_err   <= 1'b0;
            end
        end
        if (r_state == ST_FOLD) begin
            for (int k = 0; k < 4; k++) begin
                if (r_scheme == SCH_MD4 || k < 2) r_chain[k] <= r_chain[k] + core_v[k];
            end
            if (r_last) begin
                r_major <= maj;
                r_minor <= (r_scheme == SCH_MD4) ? r_chain[2] + core_v[2]
                                                 : r_chain[1] + core_v[1];
                r_err   <= 1'b0;
            end
        end
    end

    assign out_ch.valid      = r_ovalid;
    assign out_ch.major_hash = r_major;
    assign out_ch.minor_hash = r_minor;
    assign out_ch.error_flag = r_err;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_err) |-> (r_major == '0 && r_minor == '0))
        else $error("error result with hash");
    a_major_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !r_major[0]) else $error("major low bit set");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROUND |-> r_round < 5'd24) else $error("round overrun");
endmodule

@@ test/tb_directory_name_hash.sv @@
// ----------------------------------------------------------------------------
// tb_directory_name_hash
// Self-checking bench for the streamed directory name hash block.
// ----------------------------------------------------------------------------
// Names are fed one byte per word under several version and seed settings.
// A local model of the three hash schemes predicts each result word, and the
// monitor compares every result against the oldest prediction. Both channels
// idle and stall at random.
module tb_directory_name_hash;
    import dnh_pkg::*;

    typedef struct {
        logic [7:0] name_byte;
        logic [7:0] name_length;
    } name_word_t;

    typedef struct {
        logic [31:0] major_hash;
        logic [31:0] minor_hash;
        logic        error_flag;
    } hash_word_t;

    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    dnh_in_if  in_ch();
    dnh_out_if out_ch();

    directory_name_hash u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    int unsigned md4_idx [24] = '{0, 1, 2, 3, 4, 5, 6, 7, 1, 3, 5, 7, 0, 2, 4, 6,
                                  3, 7, 2, 6, 1, 5, 0, 4};
    int unsigned md4_rot [24] = '{3, 7, 11, 19, 3, 7, 11, 19, 3, 5, 9, 13, 3, 5, 9, 13,
                                  3, 9, 11, 15, 3, 9, 11, 15};

    // Shadow of the configuration registers and of the hashing state.
    logic [2:0]  cur_version;
    logic [31:0] cur_seed [4];
    logic [31:0] chain [4];
    logic [31:0] legacy_h [2];
    logic [31:0] chunk_buf [8];
    int          name_pos;
    int          name_len;
    logic [2:0]  name_version;

    name_word_t  pending_bytes [$];
    hash_word_t  expected_hashes [$];
    int          n_sent;
    int          n_taken;
    int          n_mismatch;
    int          cycle_count;
    int          in_gap;
    int          out_gap;
    bit          no_idle;
    bit          took;
    name_word_t  cur_word;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic md4_compress();
        logic [31:0] v [4];
        logic [31:0] x, y, z, f;
        int unsigned t;
        for (int k = 0; k < 4; k++) v[k] = chain[k];
        for (int k = 0; k < 24; k++) begin
            t = (4 - (k & 3)) & 3;
            x = v[(t + 1) & 3];
            y = v[(t + 2) & 3];
            z = v[(t + 3) & 3];
            if (k < 8) f = (x & y) | (~x & z);
            else if (k < 16) f = ((x & y) | (x & z) | (y & z)) + K_MD4_2;
            else f = (x ^ y ^ z) + K_MD4_3;
            v[t] = rotl(v[t] + f + chunk_buf[md4_idx[k]], md4_rot[k]);
        end
        for (int k = 0; k < 4; k++) chain[k] = chain[k] + v[k];
    endtask

    task automatic tea_compress();
        logic [31:0] x, y, sum;
        x = chain[0];
        y = chain[1];
        sum = 32'd0;
        for (int n = 0; n < 16; n++) begin
            sum = sum + K_DELTA;
            x = x + (((y << 4) + chunk_buf[0]) ^ (y + sum) ^ ((y >> 5) + chunk_buf[1]));
            y = y + (((x << 4) + chunk_buf[2]) ^ (x + sum) ^ ((x >> 5) + chunk_buf[3]));
        end
        chain[0] = chain[0] + x;
        chain[1] = chain[1] + y;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic [7:0] len);
        hash_word_t  res;
        logic [31:0] bx, h0, pad;
        int          p, o, csize, scheme;
        bit          last;
        res.major_hash = 32'd0;
        res.minor_hash = 32'd0;
        res.error_flag = 1'b1;
        if (name_pos == 0) begin
            name_len = len;
            name_version = cur_version;
            if (name_len == 0) begin
                expected_hashes.push_back(res);
                return;
            end
            if ((cur_seed[0] | cur_seed[1] | cur_seed[2] | cur_seed[3]) == 32'd0) begin
                chain = '{K_IV0, K_IV1, K_IV2, K_IV3};
            end else begin
                chain = cur_seed;
            end
            legacy_h = '{K_LEG0, K_LEG1};
        end
        p = name_pos;
        last = (p + 1 >= name_len);
        name_pos = last ? 0 : p + 1;
        if (name_version > 3'd5) begin
            if (last) expected_hashes.push_back(res);
            return;
        end
        res.error_flag = 1'b0;
        scheme = name_version % 3;
        bx = (name_version >= 3'd3) ? {24'd0, b} : {{24{b[7]}}, b};
        if (scheme == 0) begin
            h0 = legacy_h[1] + (legacy_h[0] ^ (bx * K_LEGMUL));
            if (h0[31]) h0 = h0 - K_LEGSUB;
            legacy_h[1] = legacy_h[0];
            legacy_h[0] = h0;
            if (!last) return;
            res.major_hash = legacy_h[0] << 1;
        end else begin
            csize = (scheme == 1) ? 32 : 16;
            o = p & (csize - 1);
            if (o == 0) begin
                pad = {4{8'(name_len - p)}};
                for (int w = 0; w < 8; w++) chunk_buf[w] = pad;
            end
            chunk_buf[o >> 2] = (chunk_buf[o >> 2] << 8) + bx;
            if (last || o == csize - 1) begin
                if (scheme == 1) md4_compress();
                else tea_compress();
            end
            if (!last) return;
            res.major_hash = (scheme == 1) ? chain[1] : chain[0];
            res.minor_hash = (scheme == 1) ? chain[2] : chain[1];
        end
        res.major_hash[0] = 1'b0;
        if (res.major_hash == 32'hFFFFFFFE) res.major_hash = 32'hFFFFFFFC;
        expected_hashes.push_back(res);
    endtask

    // Input driver.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || took) begin
                if (in_gap > 0 || pending_bytes.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    in_ch.valid <= 1'b0;
                end else begin
                    cur_word = pending_bytes.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.name_byte <= cur_word.name_byte;
                    in_ch.name_length <= cur_word.name_length;
                    in_gap = pick_gap();
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
            end
        end
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        hash_word_t want;
        took = i_rst_n && in_ch.valid && in_ch.ready;
        if (took) begin
            n_taken++;
            absorb_byte(in_ch.name_byte, in_ch.name_length);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_hashes.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Unexpected result word: major %h minor %h error %b",
                             out_ch.major_hash, out_ch.minor_hash, out_ch.error_flag);
            end else begin
                want = expected_hashes.pop_front();
                if (out_ch.major_hash !== want.major_hash
                        || out_ch.minor_hash !== want.minor_hash
                        || out_ch.error_flag !== want.error_flag) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("Mismatch: expected %h %h %b, got %h %h %b",
                                 want.major_hash, want.minor_hash, want.error_flag,
                                 out_ch.major_hash, out_ch.minor_hash,
                                 out_ch.error_flag);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_VERSION) cur_version = val[2:0];
        else cur_seed[idx - CFG_SEED0] = val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_name(input int len, input int fill);
        name_word_t w;
        for (int i = 0; i < len; i++) begin
            w.name_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            w.name_length = (i == 0) ? 8'(len) : 8'($urandom);
            pending_bytes.push_back(w);
            n_sent++;
        end
    endtask

    task automatic wait_idle();
        while (n_taken != n_sent || expected_hashes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        int budget;
        int len;
        logic [31:0] s;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_VERSION;
        cfg_wdata = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.name_byte = 8'd0;
        in_ch.name_length = 8'd0;
        out_ch.ready = 1'b0;
        cur_version = 3'd1;
        cur_seed = '{K_IV0, K_IV1, K_IV2, K_IV3};
        chain = '{default: 32'd0};
        legacy_h = '{default: 32'd0};
        chunk_buf = '{default: 32'd0};
        name_pos = 0;
        name_len = 0;
        name_version = 3'd0;
        n_sent = 0;
        n_taken = 0;
        n_mismatch = 0;
        cycle_count = 0;
        in_gap = 0;
        out_gap = 0;
        no_idle = 1'b0;
        took = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed names under the reset settings, then per version.
        send_name(1, 8'h00);
        send_name(3, 8'hFF);
        send_name(32, 8'h80);
        send_name(33, 8'h7F);
        send_name(0, 0);
        pending_bytes.push_back('{name_byte: 8'h41, name_length: 8'd0});
        n_sent++;
        send_name(255, -1);
        wait_idle();
        for (int v = 0; v < 8; v++) begin
            write_reg(CFG_VERSION, 32'(v));
            send_name(1, 8'hFF);
            send_name(16, 8'h80);
            send_name(17, -1);
            wait_idle();
        end

        for (int phase = 0; phase < 12; phase++) begin
            no_idle = (phase % 4 == 3);
            write_reg(CFG_VERSION, (phase < 8) ? 32'(phase) : 32'($urandom_range(0, 5)));
            for (int i = 0; i < 4; i++) begin
                case (phase % 4)
                    0: s = 32'd0;
                    1: s = 32'hFFFFFFFF;
                    default: s = $urandom;
                endcase
                write_reg(CFG_SEED0 + 3'(i), s);
            end
            budget = 30;
            while (budget > 0) begin
                len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(1, 40);
                send_name(len, -1);
                budget -= len;
            end
            wait_idle();
        end

        if (n_mismatch == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
